/* hdl/bdb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdb_pkg
// Shared types and constants for the button debounce and press/hold qualifier.
// ----------------------------------------------------------------------------
package bdb_pkg;

    // State encoding of the button state machine.
    localparam logic [2:0] ST_RESET     = 3'd0;
    localparam logic [2:0] ST_WAIT      = 3'd1;
    localparam logic [2:0] ST_ARMING    = 3'd2;
    localparam logic [2:0] ST_ARMED     = 3'd3;
    localparam logic [2:0] ST_DRAWN     = 3'd4;
    localparam logic [2:0] ST_TRIGGERED = 3'd5;
    localparam logic [2:0] ST_HOLD      = 3'd6;
    localparam logic [2:0] ST_LOWWAIT   = 3'd7;

    // Register indexes as decoded from paddr[2].
    localparam logic REG_BOUNCE = 1'b0;
    localparam logic REG_HOLD   = 1'b1;

    // Register reset values.
    localparam logic [15:0] BOUNCE_RESET = 16'd50;
    localparam logic [15:0] HOLD_RESET   = 16'd1000;

    typedef struct packed {
        logic [15:0] bounce_delay_ms;
        logic [15:0] hold_delay_ms;
    } cfg_t;

    typedef struct packed {
        logic [2:0] button_state;
        logic       short_press;
        logic       long_press;
    } result_t;

endpackage

/* hdl/bdb_cfg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdb_cfg
// APB register bank holding the bounce and hold delays.
// ----------------------------------------------------------------------------
module bdb_cfg (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [2:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready,
    output bdb_pkg::cfg_t  cfg
);

    logic [15:0] bounce_reg;
    logic [15:0] hold_reg;
    logic        wr_en;

    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bounce_reg <= bdb_pkg::BOUNCE_RESET;
            hold_reg   <= bdb_pkg::HOLD_RESET;
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                bdb_pkg::REG_BOUNCE: bounce_reg <= pwdata[15:0];
                bdb_pkg::REG_HOLD:   hold_reg   <= pwdata[15:0];
                default:             bounce_reg <= bounce_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            bdb_pkg::REG_BOUNCE: prdata = {16'd0, bounce_reg};
            bdb_pkg::REG_HOLD:   prdata = {16'd0, hold_reg};
            default:             prdata = 32'd0;
        endcase
    end

    assign cfg.bounce_delay_ms = bounce_reg;
    assign cfg.hold_delay_ms   = hold_reg;

endmodule

/* hdl/bdb_fsm.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdb_fsm
// Button state machine and press timestamp; advances once per transaction.
// ----------------------------------------------------------------------------
module bdb_fsm (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic              pin_level,
    input  logic [31:0]       now_ms,
    input  bdb_pkg::cfg_t     cfg,
    output bdb_pkg::result_t  result
);

    logic [2:0]  state_reg;
    logic [2:0]  state_next;
    logic [31:0] start_reg;
    logic [31:0] start_next;
    logic [31:0] elapsed;
    logic        bounce_done;
    logic        hold_done;

    // Elapsed time wraps modulo 2^32.
    assign elapsed     = now_ms - start_reg;
    assign bounce_done = elapsed > {16'd0, cfg.bounce_delay_ms};
    assign hold_done   = elapsed > {16'd0, cfg.hold_delay_ms};

    always_comb
    begin
        state_next = state_reg;
        start_next = start_reg;
        unique case (state_reg)
            bdb_pkg::ST_RESET:
            begin
                state_next = bdb_pkg::ST_WAIT;
            end
            bdb_pkg::ST_WAIT:
            begin
                if (!pin_level)
                    state_next = bdb_pkg::ST_ARMING;
            end
            bdb_pkg::ST_ARMING:
            begin
                start_next = now_ms;
                state_next = bdb_pkg::ST_ARMED;
            end
            bdb_pkg::ST_ARMED:
            begin
                // A release during debounce wins over the bounce timeout.
                if (pin_level)
                    state_next = bdb_pkg::ST_RESET;
                else if (bounce_done)
                    state_next = bdb_pkg::ST_DRAWN;
            end
            bdb_pkg::ST_DRAWN:
            begin
                // Long press wins over a release in the same sample.
                if (hold_done)
                    state_next = bdb_pkg::ST_HOLD;
                else if (pin_level)
                    state_next = bdb_pkg::ST_TRIGGERED;
            end
            bdb_pkg::ST_TRIGGERED:
            begin
                state_next = bdb_pkg::ST_RESET;
            end
            bdb_pkg::ST_HOLD:
            begin
                state_next = bdb_pkg::ST_LOWWAIT;
            end
            bdb_pkg::ST_LOWWAIT:
            begin
                if (pin_level)
                    state_next = bdb_pkg::ST_RESET;
            end
            default:
            begin
                state_next = bdb_pkg::ST_RESET;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bdb_pkg::ST_RESET;
            start_reg <= 32'd0;
        end
        else if (step)
        begin
            state_reg <= state_next;
            start_reg <= start_next;
        end
    end

    assign result.button_state = state_next;
    assign result.short_press  = (state_next == bdb_pkg::ST_TRIGGERED);
    assign result.long_press   = (state_next == bdb_pkg::ST_HOLD);

endmodule

/* hdl/button_debounce_press_hold_fsm.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_debounce_press_hold_fsm
// Debounces an active-low push button and reports short and long presses.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake             Payload
//   -------   -------------------   -------------------------------------------
//   in        in_valid / in_stall   pin_level, now_ms
//   out       out_valid / out_stall button_state, short_press, long_press
//   config    APB (psel..pready)    bounce_delay_ms @ 0x0, hold_delay_ms @ 0x4
//
// One transaction is accepted per cycle when the output side keeps up; each
// sample produces exactly one result, loaded into the result register once
// that register is free, and out_valid is set when the result is loaded.
// The state machine step sits between the input and result registers.
// Reset returns the machine to its reset state with a zero press timestamp and
// loads the delays with 50 ms and 1000 ms.
// A stall on the output holds the result register, which in turn holds any
// sample in the input register and raises in_stall until the result is taken.
// ----------------------------------------------------------------------------
module button_debounce_press_hold_fsm (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic        pin_level,
    input  logic [31:0] now_ms,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  button_state,
    output logic        short_press,
    output logic        long_press,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    bdb_pkg::cfg_t    cfg;
    bdb_pkg::result_t step_result;

    // Input register.
    logic        s0_valid_reg;
    logic        s0_valid_next;
    logic        s0_pin_reg;
    logic [31:0] s0_now_reg;

    // Result register.
    logic        out_valid_reg;
    logic        out_valid_next;
    bdb_pkg::result_t out_reg;

    logic        out_free;
    logic        advance;
    logic        in_take;

    // The result register can take a new value when it is empty or its
    // current value is leaving this cycle.
    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = s0_valid_reg && out_free;
    assign in_stall = s0_valid_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    assign s0_valid_next  = in_take || (s0_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !out_free);

    bdb_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // The state machine steps only when the sample moves into the result
    // register, so every accepted sample is applied exactly once and in order.
    bdb_fsm u_fsm (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .pin_level (s0_pin_reg),
        .now_ms    (s0_now_reg),
        .cfg       (cfg),
        .result    (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s0_valid_reg  <= s0_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s0_pin_reg <= pin_level;
            s0_now_reg <= now_ms;
        end
        if (advance)
        begin
            out_reg <= step_result;
        end
    end

    assign out_valid    = out_valid_reg;
    assign button_state = out_reg.button_state;
    assign short_press  = out_reg.short_press;
    assign long_press   = out_reg.long_press;

`ifndef SYNTHESIS
    // A short and a long press are never reported for the same sample.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(short_press && long_press))
        else $error("short and long press reported together");

    // The press flags follow the reported state.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (short_press == (button_state == bdb_pkg::ST_TRIGGERED)) &&
                      (long_press == (button_state == bdb_pkg::ST_HOLD)))
        else $error("press flags disagree with button state");

    // The input side only stalls behind a held result.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall && s0_valid_reg))
        else $error("input stalled without a held result");

    // A sample that moves forward always shows up as a result.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid)
        else $error("advanced sample did not reach the output");
`endif

endmodule
